// ===== hdl/accumulator_cpu_step_core_assert.svh =====
// Assertion macros shared by the accumulator machine RTL.
`ifndef ACCUMULATOR_CPU_STEP_CORE_ASSERT_SVH
`define ACCUMULATOR_CPU_STEP_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ACS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acs_pkg.sv =====
// Types and constants of the accumulator machine.
package acs_pkg;

    localparam int WORD_W    = 16;
    localparam int PC_W      = 9;
    localparam int OPND_W    = 12;
    localparam int OPC_W     = 4;
    localparam int LADDR_W   = 8;
    // wide enough to hold any address bound of the program memory
    localparam int CMP_W     = 13;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_EXEC  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MEMERR  = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_HALT    = 2'd3
    } status_t;

    localparam logic [OPC_W-1:0] OP_LOADI = 4'h0;
    localparam logic [OPC_W-1:0] OP_LOAD  = 4'h1;
    localparam logic [OPC_W-1:0] OP_STORE = 4'h3;
    localparam logic [OPC_W-1:0] OP_ADD   = 4'h5;
    localparam logic [OPC_W-1:0] OP_HALT  = 4'hC;

endpackage

// ===== hdl/acs_ram.sv =====
// Program memory: one write port, one read port, registered read data.
module acs_ram
    import acs_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/accumulator_cpu_step_core.sv =====
// Top level of the accumulator machine: request sequencer, machine state, result register.
//
// One item is in work at a time and a new one is taken in the cycle the previous one
// completes, while the finished result may still wait in the output register. A write,
// start or unknown request completes in the issue state. An execute item completes in
// the fetch state for loadi, store, halt, illegal opcode and operand address errors, in
// the operand state for load and add, or in the issue state when the machine is stopped
// or the program counter is out of range; the dependent operand read follows the fetch
// through the single read port. Memory contents are undefined after reset: no clearing pass.
`include "accumulator_cpu_step_core_assert.svh"

module accumulator_cpu_step_core
    import acs_pkg::*;
#(
    parameter int MEM_WORDS = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [LADDR_W-1:0]  load_addr,
    input  logic [WORD_W-1:0]   load_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PC_W-1:0]     pc_now,
    output logic signed [WORD_W-1:0] acc_now,
    output logic                is_halted,
    output logic [1:0]          status
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [CMP_W-1:0] MEM_LIM = CMP_W'(MEM_WORDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_FETCH,
        S_OPER
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg;
    logic [LADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               is_add_reg, is_add_next;

    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic               stopped_reg, stopped_next;
    status_t            st_next;

    logic               out_valid_reg;
    logic [PC_W-1:0]    out_pc_reg;
    logic [WORD_W-1:0]  out_acc_reg;
    logic               out_halted_reg;
    status_t            out_status_reg;

    logic               in_xfer;
    logic               slot_free;
    logic               fin;
    logic               done;
    logic               we_want;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;

    logic [OPC_W-1:0]   opcode;
    logic [OPND_W-1:0]  operand;
    logic [CMP_W-1:0]   laddr_ext;
    logic [CMP_W-1:0]   pc_ext;
    logic [CMP_W-1:0]   opnd_ext;

    assign opcode    = mem_rdata[WORD_W-1 -: OPC_W];
    assign operand   = mem_rdata[OPND_W-1:0];
    assign laddr_ext = {{(CMP_W-LADDR_W){1'b0}}, addr_reg};
    assign pc_ext    = {{(CMP_W-PC_W){1'b0}}, pc_reg};
    assign opnd_ext  = {{(CMP_W-OPND_W){1'b0}}, operand};

    assign slot_free = !out_valid_reg || out_ready;
    assign done      = fin && slot_free;
    assign mem_we    = we_want && done;
    assign in_ready  = (state_reg == S_IDLE) || done;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        is_add_next  = is_add_reg;
        acc_next     = acc_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        st_next      = ST_OK;
        fin          = 1'b0;
        we_want      = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = laddr_ext[AW-1:0];
        mem_wdata    = word_reg;
        mem_raddr    = pc_ext[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_ISSUE:
            begin
                unique case (req_reg)
                    REQ_WRITE:
                    begin
                        fin     = 1'b1;
                        we_want = (laddr_ext < MEM_LIM);
                    end
                    REQ_START:
                    begin
                        fin          = 1'b1;
                        acc_next     = '0;
                        pc_next      = '0;
                        stopped_next = 1'b0;
                    end
                    REQ_EXEC:
                    begin
                        if (stopped_reg)
                        begin
                            fin = 1'b1;
                        end
                        else if (pc_ext >= MEM_LIM)
                        begin
                            fin          = 1'b1;
                            stopped_next = 1'b1;
                            st_next      = ST_MEMERR;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                    REQ_NONE:
                    begin
                        fin = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_FETCH:
            begin
                mem_raddr = opnd_ext[AW-1:0];
                mem_waddr = opnd_ext[AW-1:0];
                mem_wdata = acc_reg;
                unique case (opcode)
                    OP_LOADI:
                    begin
                        fin      = 1'b1;
                        acc_next = {{(WORD_W-OPND_W){operand[OPND_W-1]}}, operand};
                        pc_next  = pc_reg + PC_W'(1);
                    end
                    OP_LOAD, OP_ADD:
                    begin
                        if (opnd_ext >= MEM_LIM)
                        begin
                            fin          = 1'b1;
                            stopped_next = 1'b1;
                            st_next      = ST_MEMERR;
                        end
                        else
                        begin
                            mem_re      = 1'b1;
                            is_add_next = (opcode == OP_ADD);
                            state_next  = S_OPER;
                        end
                    end
                    OP_STORE:
                    begin
                        fin = 1'b1;
                        if (opnd_ext >= MEM_LIM)
                        begin
                            stopped_next = 1'b1;
                            st_next      = ST_MEMERR;
                        end
                        else
                        begin
                            we_want = 1'b1;
                            pc_next = pc_reg + PC_W'(1);
                        end
                    end
                    OP_HALT:
                    begin
                        fin          = 1'b1;
                        stopped_next = 1'b1;
                        st_next      = ST_HALT;
                    end
                    default:
                    begin
                        fin          = 1'b1;
                        stopped_next = 1'b1;
                        st_next      = ST_ILLEGAL;
                    end
                endcase
            end
            S_OPER:
            begin
                fin      = 1'b1;
                acc_next = is_add_reg ? (acc_reg + mem_rdata) : mem_rdata;
                pc_next  = pc_reg + PC_W'(1);
            end
            default:
            begin
            end
        endcase

        // a finished item frees the sequencer; a new transfer may follow at once
        if (in_xfer)
        begin
            state_next = S_ISSUE;
        end
        else if (done)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            is_add_reg     <= 1'b0;
            acc_reg        <= '0;
            pc_reg         <= '0;
            stopped_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_add_reg <= is_add_next;
            if (done)
            begin
                acc_reg       <= acc_next;
                pc_reg        <= pc_next;
                stopped_reg   <= stopped_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= req_t'(req_type);
            addr_reg <= load_addr;
            word_reg <= load_word;
        end
        if (done)
        begin
            out_pc_reg     <= pc_next;
            out_acc_reg    <= acc_next;
            out_halted_reg <= stopped_next;
            out_status_reg <= st_next;
        end
    end

    // a store completes its item, so the next fetch always sees the written word
    acs_ram #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign pc_now    = out_pc_reg;
    assign acc_now   = out_acc_reg;
    assign is_halted = out_halted_reg;
    assign status    = out_status_reg;

    `ACS_ASSERT_NOW(a_oper_after_fetch, state_reg == S_OPER, ($past(state_reg) == S_FETCH) || ($past(state_reg) == S_OPER), "operand read without a preceding fetch")
    `ACS_ASSERT_NOW(a_write_on_done, mem_we, done, "memory written without completing an item")
    `ACS_ASSERT_NOW(a_done_slot, done, slot_free, "item completed into an occupied result register")
    `ACS_ASSERT_NOW(a_busy_no_accept, (state_reg != S_IDLE) && !done, !in_ready, "new item taken while one is in work")
    `ACS_ASSERT_NEXT(a_done_result, done, out_valid_reg, "completed item left no result")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the accumulator machine core.
module tb_top;
    import acs_pkg::*;

    localparam int MEM_WORDS   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_CYCLES  = 20;
    localparam int PROGRAMS    = 16;
    // an opcode that the machine does not implement
    localparam logic [OPC_W-1:0] OP_BAD = 4'h2;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [WORD_W-1:0] acc;
        logic              halted;
        status_t           status;
    } mach_state_t;

    typedef struct packed {
        req_t                req;
        logic [LADDR_W-1:0]  addr;
        logic [WORD_W-1:0]   word;
        logic                typed;
        mach_state_t         res;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type = REQ_NONE;
    logic [LADDR_W-1:0]  load_addr = '0;
    logic [WORD_W-1:0]   load_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [PC_W-1:0]     pc_now;
    logic signed [WORD_W-1:0] acc_now;
    logic                is_halted;
    logic [1:0]          status;

    // predicted machine state
    logic [WORD_W-1:0]   sim_mem [MEM_WORDS];
    bit                  sim_written [MEM_WORDS];
    logic [WORD_W-1:0]   sim_acc = '0;
    logic [PC_W-1:0]     sim_pc = '0;
    logic                sim_halted = 1'b1;

    mach_state_t         expected_states [$];
    mach_state_t         typed_res;
    mach_state_t         step_res;
    mach_state_t         want;
    logic                use_typed = 1'b0;
    int                  fail_count = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    int                  hold_requests = 0;
    int                  holds_done = 0;
    int                  rx_mode = 0;
    int                  rx_left = 0;
    stim_row_t           dir_rows [24];

    accumulator_cpu_step_core #(.MEM_WORDS(MEM_WORDS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .load_addr (load_addr),
        .load_word (load_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pc_now    (pc_now),
        .acc_now   (acc_now),
        .is_halted (is_halted),
        .status    (status)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_states.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Run one instruction, or apply a write or start, on the predicted state.
    task automatic machine_advance(input logic [1:0] req, input logic [LADDR_W-1:0] addr,
                                   input logic [WORD_W-1:0] word, output mach_state_t r);
        logic [WORD_W-1:0] instr;
        logic [OPC_W-1:0]  opc;
        logic [OPND_W-1:0] opnd;
        status_t           st;
        st = ST_OK;
        case (req)
            REQ_WRITE:
            begin
                if (addr < MEM_WORDS)
                begin
                    sim_mem[addr] = word;
                    sim_written[addr] = 1'b1;
                end
            end
            REQ_START:
            begin
                sim_acc = '0;
                sim_pc = '0;
                sim_halted = 1'b0;
            end
            REQ_EXEC:
            begin
                if (!sim_halted)
                begin
                    if (sim_pc >= MEM_WORDS)
                    begin
                        sim_halted = 1'b1;
                        st = ST_MEMERR;
                    end
                    else
                    begin
                        instr = sim_mem[sim_pc];
                        opc = instr[15:12];
                        opnd = instr[11:0];
                        if (opc == OP_LOADI)
                        begin
                            sim_acc = {{(WORD_W-OPND_W){opnd[OPND_W-1]}}, opnd};
                            sim_pc = sim_pc + PC_W'(1);
                        end
                        else if (opc == OP_LOAD || opc == OP_STORE || opc == OP_ADD)
                        begin
                            if (opnd >= MEM_WORDS)
                            begin
                                sim_halted = 1'b1;
                                st = ST_MEMERR;
                            end
                            else
                            begin
                                if (opc == OP_LOAD)
                                    sim_acc = sim_mem[opnd];
                                else if (opc == OP_STORE)
                                begin
                                    sim_mem[opnd] = sim_acc;
                                    sim_written[opnd] = 1'b1;
                                end
                                else
                                    sim_acc = sim_acc + sim_mem[opnd];
                                sim_pc = sim_pc + PC_W'(1);
                            end
                        end
                        else if (opc == OP_HALT)
                        begin
                            sim_halted = 1'b1;
                            st = ST_HALT;
                        end
                        else
                        begin
                            sim_halted = 1'b1;
                            st = ST_ILLEGAL;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.pc = sim_pc;
        r.acc = sim_acc;
        r.halted = sim_halted;
        r.status = st;
    endtask

    task automatic report_field(input string fname, input logic [31:0] e, input logic [31:0] g);
        if (g !== e)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, e, g);
            fail_count++;
        end
    endtask

    // Check each result transfer against the oldest expectation; predict each input transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    $display("%0t: unexpected result, got pc %0h acc %0h halted %0b status %0d",
                             $time, pc_now, acc_now, is_halted, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    report_field("pc_now", 32'(want.pc), 32'(pc_now));
                    report_field("acc_now", 32'(want.acc), 32'($unsigned(acc_now)));
                    report_field("is_halted", 32'(want.halted), 32'(is_halted));
                    report_field("status", 32'(want.status), 32'(status));
                end
            end
            if (in_valid && in_ready)
            begin
                machine_advance(req_type, load_addr, load_word, step_res);
                expected_states.push_back(use_typed ? typed_res : step_res);
            end
        end
    end

    // Receiver: stall on a pattern of its own, with one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(8, 60);
                end
                rx_left--;
                case (rx_mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Entered at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] req, input logic [LADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] word, input logic typed = 1'b0,
                             input mach_state_t res = '0);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_type = req;
        load_addr = addr;
        load_word = word;
        use_typed = typed;
        typed_res = res;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Fill any word the next instruction would read before it is ever written.
    task automatic send_exec();
        logic [WORD_W-1:0] instr;
        if (!sim_halted && sim_pc < MEM_WORDS)
        begin
            if (!sim_written[sim_pc])
                send_item(REQ_WRITE, sim_pc[LADDR_W-1:0], 16'($urandom_range(0, 65535)));
            instr = sim_mem[sim_pc];
            if ((instr[15:12] == OP_LOAD || instr[15:12] == OP_ADD) && instr[11:0] < MEM_WORDS
                && !sim_written[instr[11:0]])
                send_item(REQ_WRITE, instr[LADDR_W-1:0], 16'($urandom_range(0, 65535)));
        end
        send_item(REQ_EXEC, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_instruction();
        int                sel;
        logic [OPC_W-1:0]  opc;
        logic [OPND_W-1:0] opnd;
        sel = $urandom_range(0, 19);
        opnd = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(256, 4095))
                                           : 12'($urandom_range(0, 255));
        if (sel < 5)
        begin
            opc = OP_LOADI;
            opnd = 12'($urandom_range(0, 4095));
        end
        else if (sel < 9)
            opc = OP_LOAD;
        else if (sel < 12)
            opc = OP_STORE;
        else if (sel < 16)
            opc = OP_ADD;
        else if (sel == 16)
            opc = OP_HALT;
        else if (sel == 17)
        begin
            do
                opc = 4'($urandom_range(0, 15));
            while (opc == OP_LOADI || opc == OP_LOAD || opc == OP_STORE || opc == OP_ADD
                   || opc == OP_HALT);
        end
        else
            return 16'($urandom_range(0, 65535));
        return {opc, opnd};
    endfunction

    initial
    begin
        int len;
        int steps;
        int sel;
        logic [OPC_W-1:0] opc;

        dir_rows = '{
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd0, 16'h0000, 1'b1, ST_OK}},
            '{REQ_NONE,  8'hFF, 16'hFFFF,            1'b1, '{9'd0, 16'h0000, 1'b1, ST_OK}},
            '{REQ_WRITE, 8'hFF, 16'hFFFF,            1'b1, '{9'd0, 16'h0000, 1'b1, ST_OK}},
            '{REQ_WRITE, 8'h00, {OP_LOADI, 12'h7FF}, 1'b1, '{9'd0, 16'h0000, 1'b1, ST_OK}},
            '{REQ_WRITE, 8'h01, {OP_LOADI, 12'h800}, 1'b0, '0},
            '{REQ_WRITE, 8'h02, {OP_ADD,   12'h0FF}, 1'b0, '0},
            '{REQ_WRITE, 8'h03, {OP_STORE, 12'h010}, 1'b0, '0},
            '{REQ_WRITE, 8'h04, {OP_LOAD,  12'h010}, 1'b0, '0},
            '{REQ_WRITE, 8'h05, {OP_ADD,   12'h100}, 1'b0, '0},
            '{REQ_START, 8'h00, 16'h0000,            1'b1, '{9'd0, 16'h0000, 1'b0, ST_OK}},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd1, 16'h07FF, 1'b0, ST_OK}},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd2, 16'hF800, 1'b0, ST_OK}},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd5, 16'hF7FF, 1'b1, ST_MEMERR}},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b0, '0},
            '{REQ_START, 8'hFF, 16'hFFFF,            1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b0, '0},
            '{REQ_WRITE, 8'h01, {OP_BAD,   12'hABC}, 1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd1, 16'h07FF, 1'b1, ST_ILLEGAL}},
            '{REQ_WRITE, 8'h00, {OP_HALT,  12'h000}, 1'b0, '0},
            '{REQ_START, 8'h00, 16'h0000,            1'b0, '0},
            '{REQ_EXEC,  8'h00, 16'h0000,            1'b1, '{9'd0, 16'h0000, 1'b1, ST_HALT}}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].word,
                      dir_rows[i].typed, dir_rows[i].res);

        // short programs from address zero, stepped with some noise mixed in
        for (int p = 0; p < PROGRAMS; p++)
        begin
            // hold the receiver off while the sender keeps offering
            if (p == 4)
                hold_requests++;
            len = $urandom_range(1, 12);
            for (int a = 0; a < len; a++)
                send_item(REQ_WRITE, 8'(a), pick_instruction());
            repeat ($urandom_range(0, 3))
                send_item(REQ_WRITE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            send_item(REQ_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            steps = $urandom_range(1, len + 3);
            for (int s = 0; s < steps; s++)
            begin
                sel = $urandom_range(0, 11);
                if (sel == 0)
                    send_item(REQ_NONE, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                else if (sel == 1)
                    send_item(REQ_WRITE, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                else if (sel == 2)
                    send_item(REQ_START, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                else
                    send_exec();
            end
        end

        drain_results();

        // fill the whole memory with straight-line code and run off its end
        for (int a = 0; a < MEM_WORDS; a++)
        begin
            sel = $urandom_range(0, 2);
            opc = (sel == 0) ? OP_LOADI : (sel == 1) ? OP_LOAD : OP_ADD;
            if (opc == OP_LOADI)
                send_item(REQ_WRITE, 8'(a), {opc, 12'($urandom_range(0, 4095))});
            else
                send_item(REQ_WRITE, 8'(a), {opc, 12'($urandom_range(0, 255))});
        end
        send_item(REQ_START, 8'h00, 16'h0000);
        repeat (MEM_WORDS + 2)
            send_exec();

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
